// ===== hw/rtl/mrrw_pkg.sv =====
// shared types and codes of the multi-reader ring writer
package mrrw_pkg;

   // field widths fixed by the item format
   localparam int POS_W  = 32;
   localparam int LEN_W  = 13;
   localparam int BYTE_W = 8;
   localparam int RIDX_W = 2;
   localparam int STAT_W = 2;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // item kinds
   localparam logic KIND_READER = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_READER  = 2'd2;

   // reader cursor update toward the cursor memory
   typedef struct packed {
      logic              we;
      logic [RIDX_W-1:0] idx;
      logic [POS_W-1:0]  pos;
   } cursor_upd_type;

   // outcome of a backlog scan
   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] worst;
   } scan_stat_type;

endpackage

// ===== hw/rtl/mrrw_if.sv =====
// request and response channel interfaces of the multi-reader ring writer

interface mrrw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [mrrw_pkg::RIDX_W-1:0]   reader_index;
   logic [mrrw_pkg::POS_W-1:0]    reader_position;
   logic                          start_req;
   logic [mrrw_pkg::LEN_W-1:0]    msg_length;
   logic [mrrw_pkg::BYTE_W-1:0]   data_byte;

   modport source (
      output valid, kind, reader_index, reader_position, start_req, msg_length, data_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, reader_index, reader_position, start_req, msg_length, data_byte,
      output ready
   );
endinterface

interface mrrw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mrrw_pkg::STAT_W-1:0]   status;
   logic                          committed;
   logic [mrrw_pkg::POS_W-1:0]    write_position;
   logic [mrrw_pkg::LEN_W-1:0]    free_bytes;

   modport source (
      output valid, status, committed, write_position, free_bytes,
      input  ready
   );
   modport sink (
      input  valid, status, committed, write_position, free_bytes,
      output ready
   );
endinterface

// ===== hw/rtl/mrrw_csr.sv =====
// configuration registers behind the apb-style port
module mrrw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mrrw_pkg::CSR_AW-1:0]   paddr,
   input  logic [mrrw_pkg::CSR_DW-1:0]   pwdata,
   output logic [mrrw_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output logic [3:0]                    size_log2,
   output logic [2:0]                    active_readers
);

   localparam logic REG_SIZE_LOG2 = 1'b0;
   localparam logic REG_ACTIVE    = 1'b1;

   logic [3:0] size_log2_ff, size_log2_in;
   logic [2:0] active_ff, active_in;
   logic       wr_en;

   // write decode, register picked by word address
   always_comb begin
      wr_en        = psel && penable && pwrite;
      size_log2_in = size_log2_ff;
      active_in    = active_ff;
      if (wr_en && (paddr[2] == REG_SIZE_LOG2)) begin
         size_log2_in = pwdata[3:0];
      end
      if (wr_en && (paddr[2] == REG_ACTIVE)) begin
         active_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= 4'd12;
         active_ff    <= 3'd1;
      end else begin
         size_log2_ff <= size_log2_in;
         active_ff    <= active_in;
      end
   end

   // read back
   assign prdata = (paddr[2] == REG_ACTIVE) ? mrrw_pkg::CSR_DW'(active_ff)
                                             : mrrw_pkg::CSR_DW'(size_log2_ff);
   assign pready         = 1'b1;
   assign size_log2      = size_log2_ff;
   assign active_readers = active_ff;

endmodule

// ===== hw/rtl/mrrw_ring_mem.sv =====
// byte storage of the ring, one write port
module mrrw_ring_mem #(
   parameter  int RING_BYTES = 4096,
   localparam int AW         = $clog2(RING_BYTES)
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [AW-1:0]                 addr,
   input  logic [mrrw_pkg::BYTE_W-1:0]   wdata
);

   logic [mrrw_pkg::BYTE_W-1:0] mem [RING_BYTES];

   // one byte stored per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

endmodule

// ===== hw/rtl/mrrw_reader_scan.sv =====
// reader cursor memory and the backlog maximum scan over it
module mrrw_reader_scan #(
   parameter  int MAX_READERS = 4,
   localparam int RA_W        = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1,
   localparam int CNT_W       = $clog2(MAX_READERS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mrrw_pkg::cursor_upd_type      upd,
   input  logic                          scan_start,
   input  logic [CNT_W-1:0]              n_readers,
   input  logic [mrrw_pkg::POS_W-1:0]    write_cursor,
   output mrrw_pkg::scan_stat_type       stat
);

   logic [mrrw_pkg::POS_W-1:0] cursor_mem [MAX_READERS];
   logic [mrrw_pkg::POS_W-1:0] rd_data_ff;

   logic                       busy_ff, busy_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;
   logic [RA_W-1:0]            cnt_ff, cnt_in;
   logic [mrrw_pkg::POS_W-1:0] worst_ff, worst_in;
   logic [mrrw_pkg::POS_W-1:0] backlog;
   logic                       cnt_last;
   logic                       upd_ok;

   // cursor memory: update port and one scan read port, cleared at reset
   assign upd_ok = upd.we && (32'(upd.idx) < MAX_READERS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_READERS; i++) begin
            cursor_mem[i] <= '0;
         end
      end else if (upd_ok) begin
         cursor_mem[RA_W'(upd.idx)] <= upd.pos;
      end
      rd_data_ff <= cursor_mem[cnt_ff];
   end

   // scan sequencer: one read issued per cycle, the max taken in the cycle after
   always_comb begin
      cnt_last  = (CNT_W'(cnt_ff) + CNT_W'(1)) == n_readers;
      backlog   = write_cursor - rd_data_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rd_vld_in = busy_ff;
      last_in   = busy_ff && cnt_last;
      worst_in  = worst_ff;
      done_in   = rd_vld_ff && last_ff;
      if (rd_vld_ff && (backlog > worst_ff)) begin
         worst_in = backlog;
      end
      if (busy_ff) begin
         cnt_in = cnt_ff + RA_W'(1);
         if (cnt_last) begin
            busy_in = 1'b0;
         end
      end
      if (scan_start) begin
         busy_in   = (n_readers != '0);
         cnt_in    = '0;
         rd_vld_in = 1'b0;
         last_in   = 1'b0;
         worst_in  = '0;
         done_in   = (n_readers == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         last_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
         worst_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         rd_vld_ff <= rd_vld_in;
         last_ff   <= last_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
         worst_ff  <= worst_in;
      end
   end

   assign stat.done  = done_ff;
   assign stat.worst = worst_ff;

endmodule

// ===== hw/rtl/multi_reader_ring_writer.sv =====
// top level of the multi-reader ring writer
// Write side of a byte ring shared by several readers, with drop-on-full.
// req_if carries items: reader cursor updates (kind 0) and write bytes
// (kind 1); the first byte of a write has start_req set and the length.
// rsp_if returns exactly one item per request item: stored, dropped or
// reader updated, with the write cursor and the free space of the latest
// write start. psel/penable/pwrite/paddr/pwdata set size_log2 (address 0)
// and active_readers (address 4); write them only while the block is idle.
// A cursor update or a non-start byte gives its result in the cycle after
// acceptance, and such items go at one per cycle while results are taken.
// A start byte scans the reader cursor memory one entry per cycle through
// its registered read port, over the n active readers (at most MAX_READERS),
// reading no entry with no active reader. No item is taken meanwhile.
// The result sits in an output register; a new item is taken only when that
// register is empty or being emptied, so a stalled receiver stalls the input.
// Reset (synchronous, active high) clears cursors, the open write and the
// registers to size_log2 12 and one active reader; the byte store is not
// cleared and the block is ready as soon as reset ends.
module multi_reader_ring_writer #(
   parameter int RING_BYTES  = 4096,
   parameter int MAX_READERS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   mrrw_req_if.sink                      req_if,
   mrrw_rsp_if.source                    rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mrrw_pkg::CSR_AW-1:0]   paddr,
   input  logic [mrrw_pkg::CSR_DW-1:0]   pwdata,
   output logic [mrrw_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int AW    = $clog2(RING_BYTES);
   localparam int CAP_W = $clog2(RING_BYTES) + 1;
   localparam int CNT_W = $clog2(MAX_READERS + 1);
   localparam int LEN_W = mrrw_pkg::LEN_W;
   localparam int POS_W = mrrw_pkg::POS_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic [3:0]                  size_log2;
   logic [2:0]                  active_readers;
   mrrw_pkg::cursor_upd_type    upd;
   mrrw_pkg::scan_stat_type     scan_stat;

   logic                        state_ff, state_in;
   logic [POS_W-1:0]            write_cursor_ff, write_cursor_in;
   logic [LEN_W-1:0]            write_offset_ff, write_offset_in;
   logic [LEN_W-1:0]            pending_len_ff, pending_len_in;
   logic                        write_open_ff, write_open_in;
   logic                        dropping_ff, dropping_in;
   logic [CAP_W-1:0]            last_free_ff, last_free_in;
   logic [LEN_W-1:0]            hold_len_ff, hold_len_in;
   logic [mrrw_pkg::BYTE_W-1:0] hold_byte_ff, hold_byte_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mrrw_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic                        rsp_committed_ff, rsp_committed_in;
   logic [POS_W-1:0]            rsp_pos_ff, rsp_pos_in;
   logic [CAP_W-1:0]            rsp_free_ff, rsp_free_in;

   logic [3:0]                  lg;
   logic [31:0]                 pow32, cap32, nr32, free32;
   logic [AW-1:0]               mask;
   logic [CNT_W-1:0]            n_readers;
   logic [CAP_W-1:0]            free_now;

   logic                        accept, scan_start, step_go, sel_start;
   logic                        eff_open, eff_drop, ends;
   logic [LEN_W-1:0]            eff_off, eff_plen, off_inc;
   logic [CAP_W-1:0]            eff_free;
   logic [mrrw_pkg::BYTE_W-1:0] eff_byte;
   logic                        ring_we;
   logic [AW-1:0]               ring_addr;
   logic [POS_W-1:0]            addr_sum;

   mrrw_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .size_log2      (size_log2),
      .active_readers (active_readers)
   );

   // capacity, address mask and active reader count
   always_comb begin
      lg        = (size_log2 == 4'd0) ? 4'd1 : size_log2;
      pow32     = 32'd1 << lg;
      cap32     = (pow32 > 32'(RING_BYTES)) ? 32'(RING_BYTES) : pow32;
      mask      = AW'(cap32 - 32'd1);
      nr32      = (32'(active_readers) > 32'(MAX_READERS)) ? 32'(MAX_READERS)
                                                           : 32'(active_readers);
      n_readers = CNT_W'(nr32);
      free32    = (scan_stat.worst >= cap32) ? 32'd0 : cap32 - scan_stat.worst;
      free_now  = CAP_W'(free32);
   end

   // handshake and reader cursor update
   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign scan_start   = accept && (req_if.kind == mrrw_pkg::KIND_BYTE) && req_if.start_req;
   assign upd.we       = accept && (req_if.kind == mrrw_pkg::KIND_READER);
   assign upd.idx      = req_if.reader_index;
   assign upd.pos      = req_if.reader_position;

   mrrw_reader_scan #(
      .MAX_READERS (MAX_READERS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .scan_start   (scan_start),
      .n_readers    (n_readers),
      .write_cursor (write_cursor_ff),
      .stat         (scan_stat)
   );

   // byte step: a start byte takes its write context from the scan result
   always_comb begin
      sel_start = (state_ff == S_SCAN);
      step_go   = (accept && (req_if.kind == mrrw_pkg::KIND_BYTE) && !req_if.start_req)
                  || (sel_start && scan_stat.done);
      eff_open  = sel_start ? (hold_len_ff != '0) : write_open_ff;
      eff_drop  = sel_start ? (32'(hold_len_ff) > 32'(free_now)) : dropping_ff;
      eff_off   = sel_start ? '0 : write_offset_ff;
      eff_plen  = sel_start ? hold_len_ff : pending_len_ff;
      eff_free  = sel_start ? free_now : last_free_ff;
      eff_byte  = sel_start ? hold_byte_ff : req_if.data_byte;
      off_inc   = eff_off + LEN_W'(1);
      ends      = off_inc >= eff_plen;
      addr_sum  = write_cursor_ff + POS_W'(eff_off);
      ring_addr = addr_sum[AW-1:0] & mask;
      ring_we   = step_go && eff_open && !eff_drop;
   end

   mrrw_ring_mem #(
      .RING_BYTES (RING_BYTES)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .addr  (ring_addr),
      .wdata (eff_byte)
   );

   // write context, sequencer state and result register
   always_comb begin
      state_in         = state_ff;
      write_cursor_in  = write_cursor_ff;
      write_offset_in  = write_offset_ff;
      pending_len_in   = pending_len_ff;
      write_open_in    = write_open_ff;
      dropping_in      = dropping_ff;
      last_free_in     = last_free_ff;
      hold_len_in      = hold_len_ff;
      hold_byte_in     = hold_byte_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_committed_in = rsp_committed_ff;
      rsp_pos_in       = rsp_pos_ff;
      rsp_free_in      = rsp_free_ff;

      if (scan_start) begin
         state_in     = S_SCAN;
         hold_len_in  = req_if.msg_length;
         hold_byte_in = req_if.data_byte;
      end
      if (sel_start && scan_stat.done) begin
         state_in = S_IDLE;
      end

      if (upd.we) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = mrrw_pkg::STATUS_READER;
         rsp_committed_in = 1'b0;
         rsp_pos_in       = write_cursor_ff;
         rsp_free_in      = last_free_ff;
      end

      if (step_go) begin
         last_free_in     = eff_free;
         pending_len_in   = eff_plen;
         rsp_valid_in     = 1'b1;
         rsp_committed_in = 1'b0;
         rsp_free_in      = eff_free;
         if (!eff_open) begin
            write_open_in   = 1'b0;
            dropping_in     = eff_drop;
            write_offset_in = eff_off;
            rsp_status_in   = mrrw_pkg::STATUS_DROPPED;
         end else begin
            rsp_status_in = eff_drop ? mrrw_pkg::STATUS_DROPPED : mrrw_pkg::STATUS_STORED;
            if (ends) begin
               write_open_in   = 1'b0;
               dropping_in     = 1'b0;
               write_offset_in = '0;
               if (!eff_drop) begin
                  write_cursor_in  = write_cursor_ff + POS_W'(eff_plen);
                  rsp_committed_in = 1'b1;
               end
            end else begin
               write_open_in   = 1'b1;
               dropping_in     = eff_drop;
               write_offset_in = off_inc;
            end
         end
         rsp_pos_in = write_cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         write_cursor_ff <= '0;
         write_offset_ff <= '0;
         pending_len_ff  <= '0;
         write_open_ff   <= 1'b0;
         dropping_ff     <= 1'b0;
         last_free_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_cursor_ff <= write_cursor_in;
         write_offset_ff <= write_offset_in;
         pending_len_ff  <= pending_len_in;
         write_open_ff   <= write_open_in;
         dropping_ff     <= dropping_in;
         last_free_ff    <= last_free_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_len_ff      <= hold_len_in;
      hold_byte_ff     <= hold_byte_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_committed_ff <= rsp_committed_in;
      rsp_pos_ff       <= rsp_pos_in;
      rsp_free_ff      <= rsp_free_in;
   end

   // result channel
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.committed      = rsp_committed_ff;
   assign rsp_if.write_position = rsp_pos_ff;
   assign rsp_if.free_bytes     = LEN_W'(32'(rsp_free_ff));

`ifndef NO_ASSERTIONS
   // a scan finishes only while the sequencer waits for it
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> (state_ff == S_SCAN))
      else $error("backlog scan finished outside a write start");

   // an open write always has bytes still to come
   a_offset_below_len: assert property (@(posedge clock) disable iff (reset)
      write_open_ff |-> (write_offset_ff < pending_len_ff))
      else $error("open write offset reached its length");

   // the write cursor moves only with a committed result
   a_cursor_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(write_cursor_ff)) |-> (rsp_valid_ff && rsp_committed_ff))
      else $error("write cursor moved without a commit");

   // a committed result is always a stored byte
   a_commit_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_committed_ff) |-> (rsp_status_ff == mrrw_pkg::STATUS_STORED))
      else $error("commit reported on a byte that was not stored");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench of the multi-reader ring writer: directed and random items checked against a predictor
`timescale 1ns / 1ps

module testbench;

   localparam int CSR_AW = mrrw_pkg::CSR_AW;
   localparam int CSR_DW = mrrw_pkg::CSR_DW;
   localparam int POS_W  = mrrw_pkg::POS_W;
   localparam int LEN_W  = mrrw_pkg::LEN_W;
   localparam int BYTE_W = mrrw_pkg::BYTE_W;
   localparam int RIDX_W = mrrw_pkg::RIDX_W;
   localparam int STAT_W = mrrw_pkg::STAT_W;

   localparam int RING_BYTES   = 4096;
   localparam int MAX_READERS  = 4;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 200;

   // register map
   localparam logic [CSR_AW-1:0] ADDR_SIZE_LOG2      = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_ACTIVE_READERS = 3'd4;
   localparam logic [CSR_DW-1:0] MASK_SIZE_LOG2      = 32'h0000_000f;
   localparam logic [CSR_DW-1:0] MASK_ACTIVE_READERS = 32'h0000_0007;
   localparam int unsigned       LEN_MAX             = (1 << LEN_W) - 1;

   typedef struct packed {
      logic              kind;
      logic [RIDX_W-1:0] reader_index;
      logic [POS_W-1:0]  reader_position;
      logic              start_req;
      logic [LEN_W-1:0]  msg_length;
      logic [BYTE_W-1:0] data_byte;
   } ring_item_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              committed;
      logic [POS_W-1:0]  write_position;
      logic [LEN_W-1:0]  free_bytes;
   } ring_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   mrrw_req_if req_if ();
   mrrw_rsp_if rsp_if ();

   multi_reader_ring_writer #(
      .RING_BYTES  (RING_BYTES),
      .MAX_READERS (MAX_READERS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted ring writer state
   logic [3:0]       ring_size_log2;
   logic [2:0]       ring_readers;
   logic [POS_W-1:0] ring_cursor;
   logic [POS_W-1:0] ring_reader_pos [MAX_READERS];
   logic [LEN_W-1:0] ring_offset;
   logic [LEN_W-1:0] ring_length;
   logic [LEN_W-1:0] ring_free;
   logic             ring_open;
   logic             ring_dropping;

   ring_result_type  expected_results [$];

   // run bookkeeping
   bit               steady;
   int unsigned      mismatches;
   int unsigned      items_sent;
   int unsigned      settings_applied;
   int unsigned      seen_stored;
   int unsigned      seen_dropped;
   int unsigned      seen_reader;
   int unsigned      seen_commits;

   // capacity in use, size 0 acting as 1 and capped at the ring size
   function automatic int unsigned ring_capacity();
      int unsigned lg;
      int unsigned cap;
      lg  = (ring_size_log2 == 4'd0) ? 1 : ring_size_log2;
      cap = 1 << lg;
      return (cap > RING_BYTES) ? RING_BYTES : cap;
   endfunction

   // capacity minus the worst wrapping backlog over the active readers
   function automatic int unsigned ring_free_space();
      int unsigned      cap;
      int unsigned      n;
      logic [POS_W-1:0] worst;
      logic [POS_W-1:0] backlog;
      cap   = ring_capacity();
      n     = (ring_readers > MAX_READERS) ? MAX_READERS : ring_readers;
      worst = '0;
      for (int i = 0; i < n; i++) begin
         backlog = ring_cursor - ring_reader_pos[i];
         if (backlog > worst) worst = backlog;
      end
      return (worst >= cap) ? 0 : cap - worst;
   endfunction

   // next result of the ring writer for one accepted item
   function automatic ring_result_type ring_predict(input ring_item_type req);
      ring_result_type res;
      res = '0;
      if (req.kind == mrrw_pkg::KIND_READER) begin
         // a 2-bit index always falls within the MAX_READERS cursor entries
         ring_reader_pos[req.reader_index] = req.reader_position;
         res.status = mrrw_pkg::STATUS_READER;
      end else begin
         // a start byte takes the fit decision and abandons any open write
         if (req.start_req) begin
            ring_free     = LEN_W'(ring_free_space());
            ring_offset   = '0;
            ring_length   = req.msg_length;
            ring_open     = (req.msg_length != '0);
            ring_dropping = (req.msg_length > ring_free);
         end
         if (!ring_open) begin
            res.status = mrrw_pkg::STATUS_DROPPED;
         end else begin
            res.status  = ring_dropping ? mrrw_pkg::STATUS_DROPPED : mrrw_pkg::STATUS_STORED;
            ring_offset = ring_offset + 1'b1;
            // last byte of the write
            if (ring_offset >= ring_length) begin
               if (!ring_dropping) begin
                  ring_cursor   = ring_cursor + ring_length;
                  res.committed = 1'b1;
               end
               ring_open     = 1'b0;
               ring_dropping = 1'b0;
               ring_offset   = '0;
            end
         end
      end
      res.write_position = ring_cursor;
      res.free_bytes     = ring_free;
      return res;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                       input logic [POS_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // result side: random stalls
   initial begin : result_stall
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall = idle_cycles();
         if (stall == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin : result_check
      ring_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: status %0d", rsp_if.status);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", POS_W'(want.status), POS_W'(rsp_if.status));
            check_field("committed", POS_W'(want.committed), POS_W'(rsp_if.committed));
            check_field("write_position", want.write_position, rsp_if.write_position);
            check_field("free_bytes", POS_W'(want.free_bytes), POS_W'(rsp_if.free_bytes));
            case (want.status)
               mrrw_pkg::STATUS_STORED:  seen_stored++;
               mrrw_pkg::STATUS_DROPPED: seen_dropped++;
               default:                  seen_reader++;
            endcase
            if (want.committed) seen_commits++;
         end
      end
   end

   // send one item, leaving valid high for a back-to-back follower
   task automatic send_item(input ring_item_type req);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.kind            <= req.kind;
      req_if.reader_index    <= req.reader_index;
      req_if.reader_position <= req.reader_position;
      req_if.start_req       <= req.start_req;
      req_if.msg_length      <= req.msg_length;
      req_if.data_byte       <= req.data_byte;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(ring_predict(req));
      items_sent++;
   endtask

   // reader cursor update, unused fields random
   task automatic send_reader(input int unsigned idx, input logic [POS_W-1:0] pos);
      ring_item_type req;
      req                 = ring_item_type'({$urandom(), $urandom(), $urandom()});
      req.kind            = mrrw_pkg::KIND_READER;
      req.reader_index    = RIDX_W'(idx);
      req.reader_position = pos;
      send_item(req);
   endtask

   // write byte, unused fields random
   task automatic send_byte(input logic start, input int unsigned len,
                            input logic [BYTE_W-1:0] data);
      ring_item_type req;
      req            = ring_item_type'({$urandom(), $urandom(), $urandom()});
      req.kind       = mrrw_pkg::KIND_BYTE;
      req.start_req  = start;
      req.msg_length = LEN_W'(len);
      req.data_byte  = data;
      send_item(req);
   endtask

   // bring some readers to within one capacity of the write cursor
   task automatic catch_up_readers();
      int unsigned count;
      int unsigned first;
      count = $urandom_range(1, MAX_READERS);
      first = $urandom_range(0, MAX_READERS - 1);
      for (int j = 0; j < count; j++)
         send_reader((first + j) % MAX_READERS, ring_cursor - $urandom_range(0, ring_capacity()));
   endtask

   // a write of len bytes, of which only nbytes are sent
   task automatic send_write(input int unsigned len, input int unsigned nbytes);
      for (int k = 0; k < nbytes; k++) begin
         if (k > 0 && $urandom_range(0, 19) == 0)
            send_reader($urandom_range(0, MAX_READERS - 1),
                        ring_cursor - $urandom_range(0, ring_capacity()));
         send_byte(k == 0, (k == 0) ? len : $urandom_range(0, LEN_MAX), $urandom());
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_SIZE_LOG2) ring_size_log2 = value[3:0];
      else ring_readers = value[2:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] mask,
                            input logic [CSR_DW-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (want & mask)) begin
         $error("register 0x%0h: expected 0x%0h, got 0x%0h", addr, want & mask, prdata & mask);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // write both registers with junk in the unused bits, then read them back
   task automatic apply_config(input int unsigned size_log2, input int unsigned readers);
      wait_idle();
      csr_write(ADDR_SIZE_LOG2, ($urandom() & ~MASK_SIZE_LOG2) | size_log2);
      csr_write(ADDR_ACTIVE_READERS, ($urandom() & ~MASK_ACTIVE_READERS) | readers);
      csr_check(ADDR_SIZE_LOG2, MASK_SIZE_LOG2, size_log2);
      csr_check(ADDR_ACTIVE_READERS, MASK_ACTIVE_READERS, readers);
      settings_applied++;
   endtask

   // mostly well-formed writes with random content, some noise
   task automatic random_traffic(input int unsigned count);
      int unsigned done_at;
      int unsigned len;
      int unsigned nbytes;
      int unsigned roll;
      done_at = items_sent + count;
      while (items_sent < done_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_reader($urandom_range(0, MAX_READERS - 1), $urandom());
         end else if (roll < 7) begin
            // reader ahead of the writer looks like a huge backlog
            send_reader($urandom_range(0, MAX_READERS - 1), ring_cursor + $urandom_range(1, 8));
         end else if (roll < 22) begin
            catch_up_readers();
         end else if (roll < 27) begin
            send_byte(1'b0, $urandom_range(0, LEN_MAX), $urandom());
         end else begin
            if ($urandom_range(0, 6) == 0) len = $urandom_range(0, LEN_MAX);
            else if (ring_capacity() >= 64) len = $urandom_range(0, 24);
            else len = $urandom_range(0, ring_capacity() + 2);
            nbytes = (len == 0) ? 1 : ((len > 48) ? $urandom_range(1, 6) : len);
            // now and then cut the write short so the next start abandons it
            if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(1, nbytes);
            send_write(len, nbytes);
         end
      end
   endtask

   task automatic test_register_defaults();
      csr_check(ADDR_SIZE_LOG2, MASK_SIZE_LOG2, 32'd12);
      csr_check(ADDR_ACTIVE_READERS, MASK_ACTIVE_READERS, 32'd1);
   endtask

   // special cases under the reset settings
   task automatic test_directed();
      steady = 1'b0;
      send_byte(1'b0, 0, 8'h00);               // stray byte
      send_byte(1'b1, 0, 8'hff);               // zero length start
      send_byte(1'b1, 3, 8'h00);               // small stored write
      send_byte(1'b0, LEN_MAX, 8'hff);
      send_byte(1'b0, 0, 8'h5a);
      send_reader(0, ring_cursor);
      send_byte(1'b1, LEN_MAX, 8'haa);         // longest length, does not fit
      send_byte(1'b0, 0, 8'h55);
      send_byte(1'b1, 2, 8'h01);               // start abandons the open write
      send_byte(1'b0, 0, 8'h02);
      send_byte(1'b1, 3, 8'h10);               // reader update in the middle of a write
      send_reader(1, 32'hffff_ffff);
      send_byte(1'b0, 0, 8'h11);
      send_byte(1'b0, 0, 8'h12);
      send_reader(0, ring_cursor - 32'd5000);  // backlog above capacity
      send_byte(1'b1, 1, 8'h20);
      send_reader(0, ring_cursor + 32'd1);     // reader ahead wraps to a huge backlog
      send_byte(1'b1, 1, 8'h21);
      send_reader(0, ring_cursor);
      send_byte(1'b1, RING_BYTES, 8'h30);      // exactly full capacity fits
      send_byte(1'b0, 0, 8'h31);
      send_byte(1'b1, 1, 8'h32);
      send_reader(2, 32'h0000_0000);
      send_reader(3, 32'hffff_ffff);
      send_reader(0, 32'h8000_0000);
   endtask

   // corner settings of both registers
   task automatic test_register_extremes();
      int unsigned sizes [5]   = '{0, 1, 15, 3, 12};
      int unsigned readers [5] = '{4, 0, 7, 2, 1};
      for (int i = 0; i < 5; i++) begin
         apply_config(sizes[i], readers[i]);
         steady = (i == 1);
         random_traffic(30);
      end
      steady = 1'b0;
   endtask

   // random phases, mostly small rings so both fits and drops occur
   task automatic test_random();
      int unsigned done_at;
      int unsigned size_log2;
      done_at = items_sent + RANDOM_ITEMS;
      while (items_sent < done_at) begin
         size_log2 = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 6) : $urandom_range(0, 15);
         apply_config(size_log2, $urandom_range(0, 7));
         steady = ($urandom_range(0, 3) == 0);
         random_traffic(50);
      end
      steady = 1'b0;
   endtask

   initial begin : main_sequence
      int unsigned drain;
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.kind            <= mrrw_pkg::KIND_READER;
      req_if.reader_index    <= '0;
      req_if.reader_position <= '0;
      req_if.start_req       <= 1'b0;
      req_if.msg_length      <= '0;
      req_if.data_byte       <= '0;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      ring_size_log2 = 4'd12;
      ring_readers   = 3'd1;
      ring_cursor    = '0;
      for (int i = 0; i < MAX_READERS; i++) ring_reader_pos[i] = '0;
      ring_offset    = '0;
      ring_length    = '0;
      ring_free      = '0;
      ring_open      = 1'b0;
      ring_dropping  = 1'b0;
      steady         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_directed();
      test_register_extremes();
      test_random();

      // drain what is still in flight
      req_if.valid <= 1'b0;
      drain = 0;
      while (expected_results.size() != 0 && drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      if (expected_results.size() != 0) begin
         $error("%0d result items never arrived", expected_results.size());
         mismatches++;
      end
      repeat (8) @(posedge clock);

      $display("covered %0d items over %0d register settings", items_sent, settings_applied);
      $display("results: %0d stored, %0d dropped, %0d reader updates, %0d writes committed",
               seen_stored, seen_dropped, seen_reader, seen_commits);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
